@@ rtl/png_scanline_unfilter_core_assert.svh @@
// ---------------------------------------------------------------------------
// png_scanline_unfilter_core_assert.svh
// Assertion macros used by the scanline unfilter port checker.
// ---------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_CORE_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_CORE_ASSERT_SVH

// Property checked at each rising edge, ignored while reset is held
`define PSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at each rising edge, reset cycles included
`define PSU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/psu_pkg.sv @@
// ---------------------------------------------------------------------------
// psu_pkg
// Shared types, codes and helper functions of the PNG scanline unfilter.
// ---------------------------------------------------------------------------
package psu_pkg;

  // Default sizing of the line store
  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_BPP_DEF   = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WIDTH_W    = 13;
  localparam int HEIGHT_W   = 16;
  localparam int MODE_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 2'd2;

  // Color modes
  localparam logic [MODE_W-1:0] MODE_GRAY       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RGB        = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GRAY_ALPHA = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RGBA       = 2'd3;

  // Filter types
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  // Result queue depth
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       has_alpha;
    logic       row_end;
    logic       image_end;
  } res_t;

  // Bytes per pixel for a color mode
  function automatic logic [2:0] bytes_per_pixel(input logic [MODE_W-1:0] mode);
    logic [2:0] n;
    unique case (mode)
      MODE_GRAY:       n = 3'd1;
      MODE_RGB:        n = 3'd3;
      MODE_GRAY_ALPHA: n = 3'd2;
      default:         n = 3'd4;
    endcase
    return n;
  endfunction

  // Paeth predictor: pick the neighbor nearest to a + b - c
  function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    logic [9:0] sum_ab;
    logic [9:0] dbl_c;
    logic [7:0] p;
    pa     = (b > c) ? 10'(b - c) : 10'(c - b);
    pb     = (a > c) ? 10'(a - c) : 10'(c - a);
    sum_ab = 10'(a) + 10'(b);
    dbl_c  = {1'b0, c, 1'b0};
    pc     = (sum_ab > dbl_c) ? (sum_ab - dbl_c) : (dbl_c - sum_ab);
    if (pa <= pb && pa <= pc) begin
      p = a;
    end else if (pb <= pc) begin
      p = b;
    end else begin
      p = c;
    end
    return p;
  endfunction

endpackage

@@ rtl/png_scanline_unfilter_core.sv @@
// ---------------------------------------------------------------------------
// png_scanline_unfilter_core
// Rebuilds PNG scanlines (none, sub, up, average, Paeth) from the inflated
// byte stream and emits one RGBA item per completed pixel.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | input     | in_valid/in_stall  | in_stream_byte
//  out     | output    | out_valid/out_stall| out_red/green/blue/alpha, flags
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
//  One byte per cycle sustained while in_stall is low. A byte's position is
//  decoded in the accept cycle and its upper neighbor is read from the line
//  store at that edge; the sample is rebuilt and written back in the next
//  cycle, when a completed pixel item is pushed into the queue for the out port.
//  Results go through a 4-entry queue; in_stall rises only when the queue
//  plus the item in flight could overflow it.
//  Reset is synchronous; there is no clearing pass: the line store is read
//  only from the second row on, after the first row has written it.
//
module png_scanline_unfilter_core #(
  parameter int MAX_WIDTH           = psu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_BYTES_PER_PIXEL = psu_pkg::MAX_BPP_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // byte input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_stream_byte,
  // pixel output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic [7:0]                     out_alpha,
  output logic                           out_has_alpha,
  output logic                           out_row_end,
  output logic                           out_image_end,
  // configuration
  input  logic                           cfg_we,
  input  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_BYTES_PER_PIXEL;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int MW_BITS     = $clog2(MAX_WIDTH + 1);
  localparam int WID_W       = ((MW_BITS > psu_pkg::WIDTH_W) ? MW_BITS : psu_pkg::WIDTH_W) + 1;
  localparam int AF_W        = ADDR_W + 3;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [psu_pkg::WIDTH_W-1:0]  cfg_width_r;
  logic [psu_pkg::HEIGHT_W-1:0] cfg_height_r;
  logic [psu_pkg::MODE_W-1:0]   cfg_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= psu_pkg::WIDTH_W'(1);
      cfg_height_r <= psu_pkg::HEIGHT_W'(1);
      cfg_mode_r   <= psu_pkg::MODE_RGBA;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psu_pkg::CFG_IMAGE_WIDTH:  cfg_width_r  <= cfg_data[psu_pkg::WIDTH_W-1:0];
        psu_pkg::CFG_IMAGE_HEIGHT: cfg_height_r <= cfg_data[psu_pkg::HEIGHT_W-1:0];
        psu_pkg::CFG_COLOR_MODE:   cfg_mode_r   <= cfg_data[psu_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: position tracking and line store prefetch
  // ---------------------------------------------------------------------
  logic                         awaiting_r, awaiting_nxt;
  logic [COL_W-1:0]             col_r, col_nxt;
  logic [psu_pkg::HEIGHT_W-1:0] row_r, row_nxt;
  logic [1:0]                   bip_r, bip_nxt;

  logic                         in_acc;
  logic [2:0]                   bpp;
  logic                         last_byte;
  logic                         last_col;
  logic                         last_row;
  logic [WID_W-1:0]             width_raw;
  logic [WID_W-1:0]             width_eff;
  logic [WID_W-1:0]             col_inc;
  logic [psu_pkg::HEIGHT_W-1:0] height_eff;
  logic [psu_pkg::HEIGHT_W:0]   row_inc;
  logic [AF_W-1:0]              addr_full;
  logic [ADDR_W-1:0]            rd_addr;
  logic                         in_slot;

  assign in_acc = in_valid && !in_stall;
  assign bpp    = psu_pkg::bytes_per_pixel(cfg_mode_r);

  // Clamp the geometry to the supported range
  always_comb begin
    width_raw = WID_W'(cfg_width_r);
    if (cfg_width_r == '0) begin
      width_eff = WID_W'(1);
    end else if (width_raw > WID_W'(MAX_WIDTH)) begin
      width_eff = WID_W'(MAX_WIDTH);
    end else begin
      width_eff = width_raw;
    end
    height_eff = (cfg_height_r == '0) ? psu_pkg::HEIGHT_W'(1) : cfg_height_r;
  end

  assign last_byte = (3'({1'b0, bip_r}) + 3'd1) >= bpp;
  assign col_inc   = WID_W'(col_r) + WID_W'(1);
  assign last_col  = col_inc >= width_eff;
  assign row_inc   = {1'b0, row_r} + 17'd1;
  assign last_row  = row_inc >= {1'b0, height_eff};

  // Line store address of the byte about to be accepted
  assign addr_full = AF_W'(col_r) * AF_W'(MAX_BYTES_PER_PIXEL) + AF_W'(bip_r);
  assign rd_addr   = addr_full[ADDR_W-1:0];
  assign in_slot   = 3'({1'b0, bip_r}) < 3'(MAX_BYTES_PER_PIXEL);

  // Advance the position on each accepted byte
  always_comb begin
    awaiting_nxt = awaiting_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    bip_nxt      = bip_r;
    if (in_acc) begin
      if (awaiting_r) begin
        awaiting_nxt = 1'b0;
        col_nxt      = '0;
        bip_nxt      = '0;
      end else if (!last_byte) begin
        bip_nxt = bip_r + 2'd1;
      end else begin
        bip_nxt = '0;
        if (last_col) begin
          col_nxt      = '0;
          awaiting_nxt = 1'b1;
          row_nxt      = last_row ? '0 : row_r + psu_pkg::HEIGHT_W'(1);
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b1;
      col_r      <= '0;
      row_r      <= '0;
      bip_r      <= '0;
    end else begin
      awaiting_r <= awaiting_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      bip_r      <= bip_nxt;
    end
  end

  // Stage 1 registers: the accepted byte and its decoded position
  logic                       s1_valid_r;
  logic                       s1_filter_r;
  logic [7:0]                 s1_byte_r;
  logic [1:0]                 s1_b_r;
  logic [ADDR_W-1:0]          s1_addr_r;
  logic                       s1_upv_r;
  logic                       s1_store_r;
  logic                       s1_last_byte_r;
  logic                       s1_last_col_r;
  logic                       s1_last_row_r;
  logic [psu_pkg::MODE_W-1:0] s1_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_filter_r    <= awaiting_r;
      s1_byte_r      <= in_stream_byte;
      s1_b_r         <= bip_r;
      s1_addr_r      <= rd_addr;
      s1_upv_r       <= (row_r != '0) && in_slot;
      s1_store_r     <= in_slot;
      s1_last_byte_r <= last_byte;
      s1_last_col_r  <= last_col;
      s1_last_row_r  <= last_row;
      s1_mode_r      <= cfg_mode_r;
    end
  end

  // ---------------------------------------------------------------------
  // Line store: previous row, one byte per entry.
  // A read and the write-back of the item just before it never hit the
  // same entry (a filter byte always separates two rows), so no forwarding.
  // ---------------------------------------------------------------------
  logic [7:0] line_mem [STORE_DEPTH];
  logic [7:0] mem_q_r;
  logic       mem_we;
  logic [7:0] rec;

  assign mem_we = s1_valid_r && !s1_filter_r && s1_store_r;

  always_ff @(posedge clk) begin
    mem_q_r <= line_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[s1_addr_r] <= rec;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: rebuild the sample, update neighbors, build the pixel item
  // ---------------------------------------------------------------------
  logic [2:0] filter_r, filter_nxt;
  logic [7:0] left_r [4];
  logic [7:0] left_nxt [4];
  logic [7:0] ul_r [4];
  logic [7:0] ul_nxt [4];
  logic [7:0] cur_r [4];
  logic [7:0] cur_nxt [4];

  logic [7:0]     nb_a;
  logic [7:0]     nb_b;
  logic [7:0]     nb_c;
  logic [8:0]     avg_sum;
  logic [7:0]     pred;
  logic           s1_data;
  logic           push;
  psu_pkg::res_t  res;

  assign s1_data = s1_valid_r && !s1_filter_r;
  assign push    = s1_data && s1_last_byte_r;

  assign nb_a    = left_r[s1_b_r];
  assign nb_c    = ul_r[s1_b_r];
  assign nb_b    = s1_upv_r ? mem_q_r : 8'd0;
  assign avg_sum = {1'b0, nb_a} + {1'b0, nb_b};

  // Select the predictor for the row's filter
  always_comb begin
    unique case (filter_r)
      psu_pkg::FILT_SUB:   pred = nb_a;
      psu_pkg::FILT_UP:    pred = nb_b;
      psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
      psu_pkg::FILT_PAETH: pred = psu_pkg::paeth_pred(nb_a, nb_b, nb_c);
      default:             pred = 8'd0;
    endcase
  end

  assign rec = s1_byte_r + pred;

  // Update filter type and neighbor bytes
  always_comb begin
    filter_nxt = filter_r;
    for (int k = 0; k < 4; k++) begin
      left_nxt[k] = left_r[k];
      ul_nxt[k]   = ul_r[k];
      cur_nxt[k]  = cur_r[k];
    end
    if (s1_valid_r && s1_filter_r) begin
      filter_nxt = (s1_byte_r > 8'd4) ? psu_pkg::FILT_NONE : s1_byte_r[2:0];
      for (int k = 0; k < 4; k++) begin
        left_nxt[k] = 8'd0;
        ul_nxt[k]   = 8'd0;
      end
    end else if (s1_data) begin
      left_nxt[s1_b_r] = rec;
      ul_nxt[s1_b_r]   = nb_b;
      cur_nxt[s1_b_r]  = rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r <= psu_pkg::FILT_NONE;
      for (int k = 0; k < 4; k++) begin
        left_r[k] <= 8'd0;
        ul_r[k]   <= 8'd0;
        cur_r[k]  <= 8'd0;
      end
    end else begin
      filter_r <= filter_nxt;
      for (int k = 0; k < 4; k++) begin
        left_r[k] <= left_nxt[k];
        ul_r[k]   <= ul_nxt[k];
        cur_r[k]  <= cur_nxt[k];
      end
    end
  end

  // Map the pixel bytes onto RGBA
  always_comb begin
    res.has_alpha = s1_mode_r[1];
    res.row_end   = s1_last_col_r;
    res.image_end = s1_last_col_r && s1_last_row_r;
    unique case (s1_mode_r)
      psu_pkg::MODE_GRAY: begin
        res.red   = cur_nxt[0];
        res.green = cur_nxt[0];
        res.blue  = cur_nxt[0];
        res.alpha = 8'd0;
      end
      psu_pkg::MODE_RGB: begin
        res.red   = cur_nxt[0];
        res.green = cur_nxt[1];
        res.blue  = cur_nxt[2];
        res.alpha = 8'd0;
      end
      psu_pkg::MODE_GRAY_ALPHA: begin
        res.red   = cur_nxt[0];
        res.green = cur_nxt[0];
        res.blue  = cur_nxt[0];
        res.alpha = cur_nxt[1];
      end
      default: begin
        res.red   = cur_nxt[0];
        res.green = cur_nxt[1];
        res.blue  = cur_nxt[2];
        res.alpha = cur_nxt[3];
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------
  psu_pkg::res_t                 fifo_r [psu_pkg::FIFO_DEPTH];
  logic [psu_pkg::FIFO_AW-1:0]   wr_ptr_r;
  logic [psu_pkg::FIFO_AW-1:0]   rd_ptr_r;
  logic [psu_pkg::FIFO_AW:0]     cnt_r;
  logic [psu_pkg::FIFO_AW:0]     cnt_nxt;
  logic                          pop;
  psu_pkg::res_t                 head;

  assign pop = out_valid && !out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (psu_pkg::FIFO_AW + 1)'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - (psu_pkg::FIFO_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + psu_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + psu_pkg::FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= res;
    end
  end

  // Hold input while the queue and the item in flight could fill it
  assign in_stall = (cnt_r + (psu_pkg::FIFO_AW + 1)'(push))
                    >= (psu_pkg::FIFO_AW + 1)'(psu_pkg::FIFO_DEPTH);

  assign head          = fifo_r[rd_ptr_r];
  assign out_valid     = (cnt_r != '0);
  assign out_red       = head.red;
  assign out_green     = head.green;
  assign out_blue      = head.blue;
  assign out_alpha     = head.alpha;
  assign out_has_alpha = head.has_alpha;
  assign out_row_end   = head.row_end;
  assign out_image_end = head.image_end;

endmodule

@@ rtl/psu_port_checker.sv @@
// ---------------------------------------------------------------------------
// psu_port_checker
// Port-level checks on the scanline unfilter result channel.
// ---------------------------------------------------------------------------
`include "png_scanline_unfilter_core_assert.svh"

module psu_port_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha,
  input logic       out_has_alpha,
  input logic       out_row_end,
  input logic       out_image_end
);

  // No item may appear right after reset
  `PSU_ASSERT_RST(a_idle_after_reset, !rst_n |=> !out_valid, "item valid after reset")

  // A stalled item stays and holds its colors and its row and image end flags
  `PSU_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_alpha) && $stable(out_row_end) && $stable(out_image_end), "stalled item changed")

  // The last pixel of the image is also the last of its row
  `PSU_ASSERT(a_image_end_row, out_valid && out_image_end |-> out_row_end, "image end without row end")

  // Alpha reads zero in modes without an alpha sample
  `PSU_ASSERT(a_alpha_zero, out_valid && !out_has_alpha |-> out_alpha == 8'd0, "alpha set without alpha sample")

endmodule

bind png_scanline_unfilter_core psu_port_checker u_psu_port_checker (.*);

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Checks the PNG scanline unfilter against its own pixel predictor: directed
// rows for each filter type and register corner, then random images with
// random idling on both channels, then a stretch at full rate.
// ---------------------------------------------------------------------------
module tb;

  localparam int LINE_BYTES = psu_pkg::MAX_WIDTH_DEF * psu_pkg::MAX_BPP_DEF;
  localparam logic [7:0] FILT_ODD_LOW  = 8'd5;
  localparam logic [7:0] FILT_ODD_HIGH = 8'hFF;
  localparam logic [psu_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                           clk            = 1'b0;
  logic                           rst_n          = 1'b0;
  logic                           in_valid       = 1'b0;
  logic                           in_stall;
  logic [7:0]                     in_stream_byte = 8'h00;
  logic                           out_valid;
  logic                           out_stall      = 1'b0;
  logic [7:0]                     out_red;
  logic [7:0]                     out_green;
  logic [7:0]                     out_blue;
  logic [7:0]                     out_alpha;
  logic                           out_has_alpha;
  logic                           out_row_end;
  logic                           out_image_end;
  logic                           cfg_we         = 1'b0;
  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index      = psu_pkg::CFG_IMAGE_WIDTH;
  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data       = '0;

  png_scanline_unfilter_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_stream_byte (in_stream_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_has_alpha  (out_has_alpha),
    .out_row_end    (out_row_end),
    .out_image_end  (out_image_end),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register shadow and decoder position
  logic [psu_pkg::WIDTH_W-1:0]  width_reg   = 13'd1;
  logic [psu_pkg::HEIGHT_W-1:0] height_reg  = 16'd1;
  logic [psu_pkg::MODE_W-1:0]   mode_reg    = psu_pkg::MODE_RGBA;
  int unsigned                  row_no      = 0;
  int unsigned                  col_no      = 0;
  int unsigned                  byte_no     = 0;
  bit                           need_filter = 1'b1;
  logic [2:0]                   row_filter  = psu_pkg::FILT_NONE;
  logic [7:0]                   left_b[4]   = '{default: 8'h00};
  logic [7:0]                   upleft_b[4] = '{default: 8'h00};
  logic [7:0]                   pix_b[4]    = '{default: 8'h00};
  logic [7:0]                   line_mem[LINE_BYTES];

  psu_pkg::res_t pixels_due[$];
  int unsigned   bad_count  = 0;
  int unsigned   bytes_sent = 0;
  bit            idle_on    = 1'b1;
  int unsigned   stall_left = 0;

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > psu_pkg::MAX_WIDTH_DEF) return psu_pkg::MAX_WIDTH_DEF;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic int unsigned pixel_size();
    case (mode_reg)
      psu_pkg::MODE_GRAY:       return 1;
      psu_pkg::MODE_RGB:        return 3;
      psu_pkg::MODE_GRAY_ALPHA: return 2;
      default:                  return 4;
    endcase
  endfunction

  // Neighbor nearest to a + b - c; ties go to a, then b
  function automatic int unsigned paeth_pick(input int a, input int b, input int c);
    int da;
    int db;
    int dc;
    da = (b > c) ? b - c : c - b;
    db = (a > c) ? a - c : c - a;
    dc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
    if (da <= db && da <= dc) return a;
    return (db <= dc) ? b : c;
  endfunction

  // Advance the decoder by one accepted byte; queue a pixel when one completes
  task automatic unfilter_byte(input logic [7:0] v);
    int unsigned   wid;
    int unsigned   hgt;
    int unsigned   slot;
    int unsigned   addr;
    int unsigned   pred;
    logic [7:0]    up;
    logic [7:0]    a;
    logic [7:0]    c;
    logic [7:0]    rec;
    bit            last_c;
    bit            last_r;
    psu_pkg::res_t px;
    if (need_filter) begin
      row_filter  = (v > 8'(psu_pkg::FILT_PAETH)) ? psu_pkg::FILT_NONE : v[2:0];
      need_filter = 1'b0;
      col_no      = 0;
      byte_no     = 0;
      left_b      = '{default: 8'h00};
      upleft_b    = '{default: 8'h00};
      return;
    end
    wid  = eff_width();
    hgt  = eff_height();
    slot = byte_no & 3;
    addr = col_no * psu_pkg::MAX_BPP_DEF + slot;
    up   = (row_no > 0 && addr < LINE_BYTES) ? line_mem[addr] : 8'h00;
    a    = left_b[slot];
    c    = upleft_b[slot];
    case (row_filter)
      psu_pkg::FILT_SUB:   pred = a;
      psu_pkg::FILT_UP:    pred = up;
      psu_pkg::FILT_AVG:   pred = (int'(a) + int'(up)) >> 1;
      psu_pkg::FILT_PAETH: pred = paeth_pick(a, up, c);
      default:             pred = 0;
    endcase
    rec            = 8'(v + pred);
    pix_b[slot]    = rec;
    left_b[slot]   = rec;
    upleft_b[slot] = up;
    if (addr < LINE_BYTES) line_mem[addr] = rec;
    if (byte_no + 1 < pixel_size()) begin
      byte_no = (byte_no + 1) & 3;
      return;
    end
    byte_no = 0;
    last_c  = (col_no + 1 >= wid);
    last_r  = (row_no + 1 >= hgt);
    case (mode_reg)
      psu_pkg::MODE_GRAY: begin
        px.red = pix_b[0]; px.green = pix_b[0]; px.blue = pix_b[0]; px.alpha = 8'h00;
      end
      psu_pkg::MODE_RGB: begin
        px.red = pix_b[0]; px.green = pix_b[1]; px.blue = pix_b[2]; px.alpha = 8'h00;
      end
      psu_pkg::MODE_GRAY_ALPHA: begin
        px.red = pix_b[0]; px.green = pix_b[0]; px.blue = pix_b[0]; px.alpha = pix_b[1];
      end
      default: begin
        px.red = pix_b[0]; px.green = pix_b[1]; px.blue = pix_b[2]; px.alpha = pix_b[3];
      end
    endcase
    px.has_alpha = (mode_reg == psu_pkg::MODE_GRAY_ALPHA || mode_reg == psu_pkg::MODE_RGBA);
    px.row_end   = last_c;
    px.image_end = last_c && last_r;
    pixels_due.push_back(px);
    if (last_c) begin
      col_no      = 0;
      need_filter = 1'b1;
      row_no      = last_r ? 0 : ((row_no + 1) & 16'hFFFF);
    end else begin
      col_no = col_no + 1;
    end
  endtask

  task automatic report_pixel(input string why, input psu_pkg::res_t want,
                              input psu_pkg::res_t got);
    bad_count++;
    if (bad_count <= 10)
      $display("%s at %0t: exp %02h%02h%02h%02h %0b%0b%0b, got %02h%02h%02h%02h %0b%0b%0b",
               why, $time, want.red, want.green, want.blue, want.alpha, want.has_alpha,
               want.row_end, want.image_end, got.red, got.green, got.blue, got.alpha,
               got.has_alpha, got.row_end, got.image_end);
  endtask

  // Compare each accepted pixel with the oldest prediction
  always @(posedge clk) begin
    psu_pkg::res_t got;
    psu_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.red       = out_red;
      got.green     = out_green;
      got.blue      = out_blue;
      got.alpha     = out_alpha;
      got.has_alpha = out_has_alpha;
      got.row_end   = out_row_end;
      got.image_end = out_image_end;
      if (pixels_due.size() == 0) begin
        report_pixel("unexpected pixel", '0, got);
      end else begin
        want = pixels_due.pop_front();
        if (got !== want) report_pixel("pixel mismatch", want, got);
      end
    end
  end

  // Receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7);
    end
    out_stall <= rst_n && (stall_left != 0);
  end

  // Send one byte, with an occasional gap ahead of it; returns on the accept edge
  task automatic push_byte(input logic [7:0] value);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_stream_byte <= value;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    unfilter_byte(value);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [psu_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [psu_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      psu_pkg::CFG_IMAGE_WIDTH:  width_reg  = data[psu_pkg::WIDTH_W-1:0];
      psu_pkg::CFG_IMAGE_HEIGHT: height_reg = data[psu_pkg::HEIGHT_W-1:0];
      psu_pkg::CFG_COLOR_MODE:   mode_reg   = data[psu_pkg::MODE_W-1:0];
      default:                   ;
    endcase
  endtask

  // Drop valid, wait out all pending pixels and the byte still in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] sample_byte();
    case ($urandom_range(0, 15))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_filter();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(FILT_ODD_LOW, FILT_ODD_HIGH));
    return 8'($urandom_range(psu_pkg::FILT_NONE, psu_pkg::FILT_PAETH));
  endfunction

  task automatic send_samples(input int unsigned n);
    repeat (n) push_byte(sample_byte());
  endtask

  task automatic send_row(input logic [7:0] filt);
    push_byte(filt);
    send_samples(eff_width() * pixel_size());
  endtask

  task automatic send_image();
    repeat (eff_height()) send_row(pick_filter());
  endtask

  // Defaults after reset: one RGBA pixel per image, odd filter codes act as none
  task automatic test_reset_defaults();
    push_byte(FILT_ODD_HIGH);
    push_byte(8'h00); push_byte(8'hFF); push_byte(8'h80); push_byte(8'h7F);
    push_byte(8'(psu_pkg::FILT_PAETH));
    push_byte(8'hFF); push_byte(8'h01); push_byte(8'hFE); push_byte(8'h00);
    settle();
  endtask

  // One row per filter type over extreme samples, in gray
  task automatic test_filter_types();
    logic [7:0] filt[6];
    logic [7:0] vals[6];
    int         r;
    filt = '{8'(psu_pkg::FILT_NONE), 8'(psu_pkg::FILT_SUB), 8'(psu_pkg::FILT_UP),
             8'(psu_pkg::FILT_AVG), 8'(psu_pkg::FILT_PAETH), FILT_ODD_LOW};
    vals = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE};
    write_reg(psu_pkg::CFG_IMAGE_WIDTH, 16'd2);
    write_reg(psu_pkg::CFG_IMAGE_HEIGHT, 16'd6);
    write_reg(psu_pkg::CFG_COLOR_MODE, 16'(psu_pkg::MODE_GRAY));
    for (r = 0; r < 6; r++) begin
      push_byte(filt[r]);
      push_byte(vals[r]);
      push_byte(vals[5 - r]);
    end
    settle();
  endtask

  // Zero width and zero height act as one
  task automatic test_zero_sizes();
    write_reg(psu_pkg::CFG_IMAGE_WIDTH, 16'd0);
    write_reg(psu_pkg::CFG_IMAGE_HEIGHT, 16'd0);
    write_reg(psu_pkg::CFG_COLOR_MODE, 16'(psu_pkg::MODE_GRAY_ALPHA));
    send_image();
    send_image();
    settle();
  endtask

  // A write to the spare index leaves every register alone
  task automatic test_spare_index();
    write_reg(CFG_SPARE, 16'hFFFF);
    send_image();
    settle();
  endtask

  // Oversized width keeps the row open; a narrower width then closes it
  task automatic test_wide_rows();
    write_reg(psu_pkg::CFG_IMAGE_WIDTH, 16'h1FFF);
    write_reg(psu_pkg::CFG_IMAGE_HEIGHT, 16'd2);
    write_reg(psu_pkg::CFG_COLOR_MODE, 16'(psu_pkg::MODE_GRAY));
    push_byte(8'(psu_pkg::FILT_SUB));
    send_samples(24);
    settle();
    write_reg(psu_pkg::CFG_IMAGE_WIDTH, 16'd25);
    send_samples(1);
    send_row(8'(psu_pkg::FILT_PAETH));
    settle();
  endtask

  // Tallest height, then cut the image short by lowering it mid-image
  task automatic test_tall_cut();
    write_reg(psu_pkg::CFG_IMAGE_WIDTH, 16'd3);
    write_reg(psu_pkg::CFG_IMAGE_HEIGHT, 16'hFFFF);
    write_reg(psu_pkg::CFG_COLOR_MODE, 16'(psu_pkg::MODE_RGB));
    repeat (3) send_row(pick_filter());
    settle();
    write_reg(psu_pkg::CFG_IMAGE_HEIGHT, 16'd0);
    send_row(8'(psu_pkg::FILT_UP));
    send_image();
    settle();
  endtask

  // Shrink the width under the current column, then narrow the mode at a row start
  task automatic test_mid_image_changes();
    write_reg(psu_pkg::CFG_IMAGE_WIDTH, 16'd6);
    write_reg(psu_pkg::CFG_IMAGE_HEIGHT, 16'd3);
    write_reg(psu_pkg::CFG_COLOR_MODE, 16'(psu_pkg::MODE_RGBA));
    send_row(8'(psu_pkg::FILT_PAETH));
    push_byte(8'(psu_pkg::FILT_AVG));
    send_samples(3 * 4);
    settle();
    write_reg(psu_pkg::CFG_IMAGE_WIDTH, 16'd2);
    send_samples(4);
    settle();
    write_reg(psu_pkg::CFG_COLOR_MODE, 16'(psu_pkg::MODE_GRAY));
    send_row(8'(psu_pkg::FILT_PAETH));
    settle();
  endtask

  // Random images of mostly small sizes, idling switched on and off
  task automatic test_random_images();
    int unsigned start;
    int unsigned wid;
    start = bytes_sent;
    while (bytes_sent - start < 800) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) != 0) begin
        settle();
        case ($urandom_range(0, 23))
          0:       wid = 0;
          1, 2:    wid = $urandom_range(9, 48);
          default: wid = $urandom_range(1, 8);
        endcase
        write_reg(psu_pkg::CFG_IMAGE_WIDTH, 16'(wid));
        write_reg(psu_pkg::CFG_IMAGE_HEIGHT, 16'($urandom_range(0, 4)));
        write_reg(psu_pkg::CFG_COLOR_MODE,
                  16'($urandom_range(psu_pkg::MODE_GRAY, psu_pkg::MODE_RGBA)));
      end
      send_image();
    end
    settle();
  endtask

  // Back-to-back images with no idling on either side
  task automatic test_full_rate();
    idle_on = 1'b0;
    settle();
    write_reg(psu_pkg::CFG_IMAGE_WIDTH, 16'd16);
    write_reg(psu_pkg::CFG_IMAGE_HEIGHT, 16'd3);
    write_reg(psu_pkg::CFG_COLOR_MODE, 16'(psu_pkg::MODE_RGBA));
    send_image();
    send_image();
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_filter_types();
    test_zero_sizes();
    test_spare_index();
    test_wide_rows();
    test_tall_cut();
    test_mid_image_changes();
    test_random_images();
    test_full_rate();
    repeat (8) @(posedge clk);
    bad_count += pixels_due.size();
    if (bad_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
